// ===== hw/rtl/ultrasonic_tank_level_ranger_top_assert.svh =====
// Assertion macros shared by the ranger checker.
`ifndef ULTRASONIC_TANK_LEVEL_RANGER_TOP_ASSERT_SVH
`define ULTRASONIC_TANK_LEVEL_RANGER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define UTLR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ranger assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define UTLR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ranger assertion failed");

`endif

// ===== hw/rtl/utlr_pkg.sv =====
// Shared types, widths and codes of the ultrasonic tank level ranger.
`default_nettype none

package utlr_pkg;

  localparam int unsigned HEIGHT_W  = 10;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned TRIGGER_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned STATUS_W  = 2;

  // Numerator is at most 20000 * 1023, the divisor at most 200 * 1023.
  localparam int unsigned NUM_W  = 25;
  localparam int unsigned DEN_W  = 18;
  // The quotient never exceeds 100, so seven bits cover it.
  localparam int unsigned QUOT_W = 7;

  localparam int unsigned FULL_SCALE  = 20000;
  localparam int unsigned SOUND_SCALE = 343;
  localparam int unsigned DEN_SCALE   = 200;
  localparam int unsigned LOW_TICKS   = 2;
  localparam int unsigned LEVEL_MAX   = 100;
  localparam int unsigned LEVEL_RESET = 50;

  localparam logic [HEIGHT_W-1:0]  HEIGHT_RESET  = HEIGHT_W'(100);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(30000);
  localparam logic [TRIGGER_W-1:0] TRIGGER_RESET = TRIGGER_W'(10);

  localparam logic [CFG_IDX_W-1:0] CFG_TANK_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER     = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_ECHO  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

  typedef struct packed {
    logic kind;
    logic echo;
  } in_t;

  typedef struct packed {
    logic                trig;
    logic                busy_res;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [TICK_W-1:0]   pulse_len;
    logic [LEVEL_W-1:0]  level_pct;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utlr_div.sv =====
// Iterative restoring divider: one compare and subtract per cycle.
`default_nettype none

module utlr_div import utlr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  output logic                   done_o,
  output logic [QUOT_W-1:0]      quot_o
);

  localparam int unsigned CNT_W = $clog2(QUOT_W);

  logic [NUM_W-1:0]  rem_q;
  logic [NUM_W-1:0]  dsh_q;
  logic [QUOT_W-1:0] quot_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic              ge;

  // The quotient is known to fit QUOT_W bits, so the divisor starts shifted
  // up by QUOT_W-1 and moves down one place per step.
  assign ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dsh_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= num_i;
        dsh_q  <= NUM_W'(den_i) << (QUOT_W - 1);
        quot_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (ge) begin
          rem_q <= rem_q - dsh_q;
        end
        quot_q <= {quot_q[QUOT_W-2:0], ge};
        dsh_q  <= dsh_q >> 1;
        cnt_q  <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ultrasonic_tank_level_ranger_top.sv =====
// Top level of the ultrasonic tank level ranger: tick sequencer and level math.
//
//   channel  direction  handshake                    payload
//   in       request    in_valid_i / in_ready_o      in_req_i  (in_t: kind, echo)
//   out      result     out_valid_o / out_ready_i    out_res_o (out_t)
//   cfg      write      cfg_we_i, cfg_idx_i          cfg_wdata_i
//
// Every request is one microsecond tick and yields exactly one result.
// A plain tick passes through S_STEP and S_FIN to a loaded result, and no new
// request is taken until the sequencer is back in S_IDLE.
// A good echo's last tick adds S_MUL, S_PREP and S_DIV, which waits out the seven
// compare-subtract steps of the shared divider; a zero height or far target skips S_DIV.
// Reset is asynchronous and active low; it restores the register defaults. A result
// that is not taken holds off the next request until out_ready_i frees its slot.
`default_nettype none

module ultrasonic_tank_level_ranger_top import utlr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_t                   in_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_t                       out_res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Measurement phase, as seen by the tick protocol.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LOW,
    PH_HIGH,
    PH_WAIT,
    PH_MEAS
  } phase_e;

  // Cycle sequencer that walks one request through the shared units.
  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_MUL,
    S_PREP,
    S_DIV,
    S_FIN
  } seq_e;

  seq_e                  st_q;
  phase_e                phase_q, phase_d;
  logic [TICK_W-1:0]     tick_q, tick_d;
  logic [TICK_W-1:0]     width_q, width_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [LEVEL_W-1:0]    level_q;
  logic                  trig_q, trig_d;
  logic                  done_q, done_d;
  logic                  calc_d;

  logic [HEIGHT_W-1:0]   height_q;
  logic [TIMEOUT_W-1:0]  timeout_q;
  logic [TRIGGER_W-1:0]  trigger_q;

  in_t                   in_q;
  out_t                  out_q;
  logic                  out_valid_q;

  logic [NUM_W-1:0]      full_q;
  logic [NUM_W-1:0]      dist_q;
  logic [NUM_W-1:0]      num_q;
  logic [DEN_W-1:0]      den_q;
  logic                  div_start_q;
  logic                  div_done;
  logic [QUOT_W-1:0]     div_quot;

  logic [TICK_W-1:0]     tmo;
  logic [TICK_W-1:0]     thi;
  logic                  in_fire;

  // Zero in either limit register behaves as one.
  assign tmo = (timeout_q == '0) ? TICK_W'(1) : TICK_W'(timeout_q);
  assign thi = (trigger_q == '0) ? TICK_W'(1) : TICK_W'(trigger_q);

  assign in_ready_o = (st_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // Protocol step for the captured tick. A start request only counts in idle
  // and the start tick itself is the first of the two low trigger ticks.
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    width_d  = width_q;
    status_d = status_q;
    trig_d   = 1'b0;
    done_d   = 1'b0;
    calc_d   = 1'b0;

    if ((phase_q == PH_IDLE) && in_q.kind) begin
      phase_d = PH_LOW;
      tick_d  = '0;
      width_d = '0;
    end

    unique case (phase_d)
      PH_IDLE: begin
      end
      PH_LOW: begin
        tick_d = tick_d + TICK_W'(1);
        if (tick_d >= TICK_W'(LOW_TICKS)) begin
          phase_d = PH_HIGH;
          tick_d  = '0;
        end
      end
      PH_HIGH: begin
        trig_d = 1'b1;
        tick_d = tick_d + TICK_W'(1);
        if (tick_d >= thi) begin
          phase_d = PH_WAIT;
          tick_d  = '0;
        end
      end
      PH_WAIT: begin
        if (in_q.echo) begin
          // The rising tick is already the first high tick.
          width_d = TICK_W'(1);
          if (width_d >= tmo) begin
            status_d = STATUS_TOO_LONG;
            done_d   = 1'b1;
            phase_d  = PH_IDLE;
          end else begin
            phase_d = PH_MEAS;
          end
        end else begin
          tick_d = tick_d + TICK_W'(1);
          if (tick_d >= tmo) begin
            status_d = STATUS_NO_ECHO;
            done_d   = 1'b1;
            phase_d  = PH_IDLE;
          end
        end
      end
      PH_MEAS: begin
        if (!in_q.echo) begin
          // Falling edge: the level is worked out in the following cycles.
          status_d = STATUS_OK;
          done_d   = 1'b1;
          calc_d   = 1'b1;
          phase_d  = PH_IDLE;
        end else begin
          width_d = width_d + TICK_W'(1);
          if (width_d >= tmo) begin
            status_d = STATUS_TOO_LONG;
            done_d   = 1'b1;
            phase_d  = PH_IDLE;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      width_q     <= '0;
      status_q    <= STATUS_OK;
      level_q     <= LEVEL_W'(LEVEL_RESET);
      trig_q      <= 1'b0;
      done_q      <= 1'b0;
      height_q    <= HEIGHT_RESET;
      timeout_q   <= TIMEOUT_RESET;
      trigger_q   <= TRIGGER_RESET;
      in_q        <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      full_q      <= '0;
      dist_q      <= '0;
      num_q       <= '0;
      den_q       <= '0;
      div_start_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TANK_HEIGHT: height_q  <= cfg_wdata_i[HEIGHT_W-1:0];
          CFG_TIMEOUT:     timeout_q <= cfg_wdata_i[TIMEOUT_W-1:0];
          CFG_TRIGGER:     trigger_q <= cfg_wdata_i[TRIGGER_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      div_start_q <= 1'b0;

      unique case (st_q)
        S_IDLE: begin
          if (in_fire) begin
            in_q <= in_req_i;
            st_q <= S_STEP;
          end
        end
        S_STEP: begin
          phase_q  <= phase_d;
          tick_q   <= tick_d;
          width_q  <= width_d;
          status_q <= status_d;
          trig_q   <= trig_d;
          done_q   <= done_d;
          st_q     <= calc_d ? S_MUL : S_FIN;
        end
        S_MUL: begin
          // Constant-coefficient products of the height and the echo width.
          full_q <= NUM_W'(FULL_SCALE) * NUM_W'(height_q);
          dist_q <= NUM_W'(SOUND_SCALE) * NUM_W'(width_q);
          den_q  <= DEN_W'(DEN_SCALE) * DEN_W'(height_q);
          st_q   <= S_PREP;
        end
        S_PREP: begin
          // A zero height or a target beyond the tank bottom reads as empty.
          if ((height_q == '0) || (dist_q >= full_q)) begin
            level_q <= '0;
            st_q    <= S_FIN;
          end else begin
            num_q       <= full_q - dist_q;
            div_start_q <= 1'b1;
            st_q        <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            level_q <= (div_quot > QUOT_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                       : LEVEL_W'(div_quot);
            st_q    <= S_FIN;
          end
        end
        S_FIN: begin
          out_q.trig      <= trig_q;
          out_q.busy_res  <= (phase_q != PH_IDLE);
          out_q.done_res  <= done_q;
          out_q.status    <= status_q;
          out_q.pulse_len <= width_q;
          out_q.level_pct <= level_q;
          out_valid_q     <= 1'b1;
          st_q            <= S_IDLE;
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  utlr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/utlr_checker.sv =====
// Port-level checker for the ranger top level, with its bind statement.
`default_nettype none
`include "ultrasonic_tank_level_ranger_top_assert.svh"

module utlr_checker import utlr_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_res_o
);

  // A tick is worked on over several cycles, so no request follows directly.
  `UTLR_ASSERT_NXT(a_accept_blocks, in_valid_i && in_ready_o, !in_ready_o)

  // A stalled result holds.
  `UTLR_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_res_o))

  // The finishing tick leaves the ranger idle.
  `UTLR_ASSERT_IMP(a_done_idle, out_valid_o && out_res_o.done_res, !out_res_o.busy_res)

  // The trigger is only driven inside a measurement that is still running.
  `UTLR_ASSERT_IMP(a_trig_busy, out_valid_o && out_res_o.trig,
                   out_res_o.busy_res && !out_res_o.done_res)

endmodule

bind ultrasonic_tank_level_ranger_top utlr_checker u_checker (.*);

`default_nettype wire
